@@ src/sit_pkg.sv @@
// ----------------------------------------------------------------------------
// sit_pkg
// Shared types and constants of the sorted interpolation table.
// ----------------------------------------------------------------------------
package sit_pkg;

    localparam int DEFAULT_DEPTH = 16;
    localparam int ADDR_W        = 4;
    localparam int DATA_W        = 32;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_UNDER_VALUE = 2'd0;
    localparam logic [1:0] REG_OVER_VALUE  = 2'd1;
    localparam logic [1:0] REG_TOLERANCE   = 2'd2;

    localparam logic [15:0] TOLERANCE_RESET = 16'd66;

    // request types
    localparam logic [1:0] REQ_CLEAR   = 2'd0;
    localparam logic [1:0] REQ_ADD     = 2'd1;
    localparam logic [1:0] REQ_LOOKUP  = 2'd2;
    localparam logic [1:0] REQ_IGNORED = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_BELOW = 3'd1;
    localparam logic [2:0] ST_ABOVE = 3'd2;
    localparam logic [2:0] ST_DUP   = 3'd3;
    localparam logic [2:0] ST_FULL  = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DUP_SCAN,
        S_INSERT,
        S_LOOK_SCAN,
        S_DIVIDE,
        S_OUTPUT
    } seq_state_t;

    typedef enum logic [1:0] {
        D_IDLE,
        D_MUL,
        D_RUN
    } div_state_t;

    // operands of one interpolation step: q = mag * num / den
    typedef struct packed {
        logic        start;
        logic [31:0] mag;
        logic [31:0] num;
        logic [31:0] den;
    } div_req_t;

endpackage

@@ src/sit_if.sv @@
// ----------------------------------------------------------------------------
// sit_if
// Request and response channels of the sorted interpolation table.
// ----------------------------------------------------------------------------
interface sit_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic signed [31:0] key_x;
    logic signed [31:0] value_y;

    modport source (output valid, output req_type, output key_x, output value_y,
                    input ready);
    modport sink   (input valid, input req_type, input key_x, input value_y,
                    output ready);
endinterface

interface sit_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_y;
    logic [2:0]         status;
    logic [4:0]         point_count;

    modport source (output valid, output result_y, output status, output point_count,
                    input ready);
    modport sink   (input valid, input result_y, input status, input point_count,
                    output ready);
endinterface

@@ src/sit_div.sv @@
// ----------------------------------------------------------------------------
// sit_div
// Multiply then restoring divide: q = (mag * num) / den, one bit a cycle.
// The caller guarantees num < den, so the quotient fits in 32 bits.
// ----------------------------------------------------------------------------
module sit_div (
    input  logic              clk,
    input  logic              rst_n,
    input  sit_pkg::div_req_t op,
    output logic              done,
    output logic [31:0]       quot
);
    import sit_pkg::*;

    div_state_t  state_reg, state_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] mag_reg, num_reg, den_reg;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] low_reg, low_next;
    logic        done_reg, done_next;
    logic [63:0] prod;
    logic [32:0] rem_sh;
    logic [32:0] rem_sub;

    assign prod    = 64'(mag_reg) * 64'(num_reg);
    assign rem_sh  = {rem_reg, low_reg[31]};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        low_next   = low_reg;
        done_next  = 1'b0;
        case (state_reg)
            D_IDLE:
            begin
                if (op.start)
                begin
                    state_next = D_MUL;
                end
            end
            D_MUL:
            begin
                rem_next   = prod[63:32];
                low_next   = prod[31:0];
                cnt_next   = 6'd0;
                state_next = D_RUN;
            end
            D_RUN:
            begin
                if (!rem_sub[32])
                begin
                    rem_next = rem_sub[31:0];
                    low_next = {low_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[31:0];
                    low_next = {low_reg[30:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                begin
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == D_IDLE && op.start)
        begin
            mag_reg <= op.mag;
            num_reg <= op.num;
            den_reg <= op.den;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        low_reg <= low_next;
    end

    assign done = done_reg;
    assign quot = low_reg;

endmodule

@@ src/sorted_interpolation_table_top.sv @@
// ----------------------------------------------------------------------------
// sorted_interpolation_table_top
// Sorted Q16.16 point table with clear, ordered insert and linear lookup.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request (clear, add point, lookup) per handshake; rsp
//   returns exactly one response per request, in order. The registers for
//   the under-range value, the over-range value and the tolerance sit on the
//   APB port at byte addresses 0, 4, 8; the user must write them only while
//   idle, and the block itself does not enforce this.
// Sequencing (n = stored points):
//   clear goes straight to the output step. add: a duplicate scan of the n
//   stored points, then shifting inserts through the point memory, one entry
//   a cycle. lookup: a scan of the memory for the bracketing pair, then the
//   multiply and bit-serial divide unit. Requests are handled one at a time.
// Reset: the table is empty and the registers take their reset values; the
//   point memories need no clearing, entries at or above the count are
//   never used.
// Stall: a finished response waits in the output register; the next request
//   is taken meanwhile and held in its last step until the register frees.
// ----------------------------------------------------------------------------
module sorted_interpolation_table_top #(
    parameter int TABLE_DEPTH = sit_pkg::DEFAULT_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    sit_req_if.sink                      req,
    sit_rsp_if.source                    rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sit_pkg::ADDR_W-1:0]   paddr,
    input  logic [sit_pkg::DATA_W-1:0]   pwdata,
    output logic [sit_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    import sit_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // configuration registers
    logic signed [31:0] below_reg;
    logic signed [31:0] above_reg;
    logic [15:0]        tol_reg;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            below_reg <= '0;
            above_reg <= '0;
            tol_reg   <= TOLERANCE_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_UNDER_VALUE: below_reg <= pwdata;
                REG_OVER_VALUE:  above_reg <= pwdata;
                REG_TOLERANCE:   tol_reg   <= pwdata[15:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_UNDER_VALUE: prdata = below_reg;
            REG_OVER_VALUE:  prdata = above_reg;
            REG_TOLERANCE:   prdata = {16'd0, tol_reg};
            default:         prdata = '0;
        endcase
    end

    // point memories
    logic signed [31:0] mem_x [TABLE_DEPTH];
    logic signed [31:0] mem_y [TABLE_DEPTH];
    logic signed [31:0] rdx_reg, rdy_reg;
    logic [CNT_W-1:0]   rd_cnt;
    logic               wr_en;
    logic signed [31:0] wr_x, wr_y;

    // sequencer state
    seq_state_t         state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   pos_reg, pos_next;
    logic signed [31:0] key_reg, val_reg;
    logic signed [31:0] px_reg, px_next;
    logic signed [31:0] py_reg, py_next;
    logic               neg_reg, neg_next;
    logic signed [31:0] res_reg, res_next;
    logic [2:0]         stat_reg, stat_next;
    logic               ov_reg;
    logic signed [31:0] out_y_reg;
    logic [2:0]         out_st_reg;
    logic [4:0]         out_cnt_reg;
    logic               out_load;
    logic               accept;

    // interpolation datapath
    div_req_t           dop;
    logic               div_done;
    logic [31:0]        div_q;
    logic signed [32:0] dup_diff;
    logic [32:0]        dup_abs;
    logic signed [32:0] dy;
    logic [32:0]        dy_abs;
    logic signed [32:0] dnum;
    logic signed [32:0] dden;
    logic [CNT_W-1:0]   last_idx;
    logic [CNT_W+4:0]   cnt_ext;

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_x[pos_reg[IDX_W-1:0]] <= wr_x;
            mem_y[pos_reg[IDX_W-1:0]] <= wr_y;
        end
        rdx_reg <= mem_x[rd_cnt[IDX_W-1:0]];
        rdy_reg <= mem_y[rd_cnt[IDX_W-1:0]];
    end

    assign accept   = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign last_idx = count_reg - CNT_W'(1);
    assign dup_diff = 33'(key_reg) - 33'(rdx_reg);
    assign dup_abs  = dup_diff[32] ? 33'(-dup_diff) : 33'(dup_diff);
    assign dy       = 33'(rdy_reg) - 33'(py_reg);
    assign dy_abs   = dy[32] ? 33'(-dy) : 33'(dy);
    assign dnum     = 33'(key_reg) - 33'(px_reg);
    assign dden     = 33'(rdx_reg) - 33'(px_reg);
    assign cnt_ext  = {5'd0, count_reg};

    sit_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (dop),
        .done  (div_done),
        .quot  (div_q)
    );

    // next state and request handling
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        neg_next   = neg_reg;
        res_next   = res_reg;
        stat_next  = stat_reg;
        rd_cnt     = '0;
        wr_en      = 1'b0;
        wr_x       = rdx_reg;
        wr_y       = rdy_reg;
        out_load   = 1'b0;
        dop.start  = 1'b0;
        dop.mag    = dy_abs[31:0];
        dop.num    = dnum[31:0];
        dop.den    = dden[31:0];
        case (state_reg)
            S_IDLE:
            begin
                idx_next  = '0;
                res_next  = '0;
                stat_next = ST_OK;
                if (accept)
                begin
                    case (req.req_type)
                        REQ_CLEAR:
                        begin
                            count_next = '0;
                            state_next = S_OUTPUT;
                        end
                        REQ_ADD:
                        begin
                            if (count_reg == '0)
                            begin
                                pos_next   = '0;
                                state_next = S_INSERT;
                            end
                            else
                            begin
                                state_next = S_DUP_SCAN;
                            end
                        end
                        REQ_LOOKUP:
                        begin
                            if (count_reg == '0)
                            begin
                                if (req.key_x < 0)
                                begin
                                    res_next  = below_reg;
                                    stat_next = ST_BELOW;
                                end
                                else if (req.key_x > 0)
                                begin
                                    res_next  = above_reg;
                                    stat_next = ST_ABOVE;
                                end
                                state_next = S_OUTPUT;
                            end
                            else
                            begin
                                state_next = S_LOOK_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_OUTPUT;
                        end
                    endcase
                end
            end
            S_DUP_SCAN:
            begin
                idx_next = idx_reg + CNT_W'(1);
                rd_cnt   = idx_next;
                if (dup_abs < {17'd0, tol_reg})
                begin
                    stat_next  = ST_DUP;
                    state_next = S_OUTPUT;
                end
                else if (idx_reg == last_idx)
                begin
                    if (count_reg >= CNT_W'(TABLE_DEPTH))
                    begin
                        stat_next  = ST_FULL;
                        state_next = S_OUTPUT;
                    end
                    else
                    begin
                        pos_next   = count_reg;
                        rd_cnt     = last_idx;
                        state_next = S_INSERT;
                    end
                end
            end
            S_INSERT:
            begin
                wr_en = 1'b1;
                if (pos_reg == '0 || !(rdx_reg > key_reg))
                begin
                    wr_x       = key_reg;
                    wr_y       = val_reg;
                    count_next = count_reg + CNT_W'(1);
                    state_next = S_OUTPUT;
                end
                else
                begin
                    pos_next = pos_reg - CNT_W'(1);
                    rd_cnt   = pos_reg - CNT_W'(2);
                end
            end
            S_LOOK_SCAN:
            begin
                idx_next = idx_reg + CNT_W'(1);
                rd_cnt   = idx_next;
                px_next  = rdx_reg;
                py_next  = rdy_reg;
                if (idx_reg == '0 && key_reg < rdx_reg)
                begin
                    res_next   = below_reg;
                    stat_next  = ST_BELOW;
                    state_next = S_OUTPUT;
                end
                else if (idx_reg != '0 && rdx_reg > key_reg)
                begin
                    dop.start  = 1'b1;
                    px_next    = px_reg;
                    py_next    = py_reg;
                    neg_next   = dy[32];
                    state_next = S_DIVIDE;
                end
                else if (idx_reg == last_idx)
                begin
                    if (key_reg > rdx_reg)
                    begin
                        res_next  = above_reg;
                        stat_next = ST_ABOVE;
                    end
                    else
                    begin
                        res_next = rdy_reg;
                    end
                    state_next = S_OUTPUT;
                end
            end
            S_DIVIDE:
            begin
                if (div_done)
                begin
                    res_next   = neg_reg ? (py_reg - $signed(div_q))
                                         : (py_reg + $signed(div_q));
                    state_next = S_OUTPUT;
                end
            end
            S_OUTPUT:
            begin
                if (!ov_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (out_load)
            begin
                ov_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg <= req.key_x;
            val_reg <= req.value_y;
        end
        idx_reg  <= idx_next;
        pos_reg  <= pos_next;
        px_reg   <= px_next;
        py_reg   <= py_next;
        neg_reg  <= neg_next;
        res_reg  <= res_next;
        stat_reg <= stat_next;
        if (out_load)
        begin
            out_y_reg   <= res_reg;
            out_st_reg  <= stat_reg;
            out_cnt_reg <= cnt_ext[4:0];
        end
    end

    assign rsp.valid       = ov_reg;
    assign rsp.result_y    = out_y_reg;
    assign rsp.status      = out_st_reg;
    assign rsp.point_count = out_cnt_reg;

endmodule

@@ test/tb_sorted_interpolation_table_top.sv @@
// ----------------------------------------------------------------------------
// tb_sorted_interpolation_table_top
// Random and directed requests against a predicted point table; responses
// are checked field by field in order, registers rewritten between phases.
// ----------------------------------------------------------------------------
module tb_sorted_interpolation_table_top;
    timeunit 1ns;
    timeprecision 1ps;
    import sit_pkg::*;

    localparam int DEPTH = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] key_x;
        logic signed [31:0] value_y;
    } request_t;

    typedef struct packed {
        logic signed [31:0] result_y;
        logic [2:0]         status;
        logic [4:0]         point_count;
    } response_t;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    sit_req_if req_ch();
    sit_rsp_if rsp_ch();

    sorted_interpolation_table_top #(.TABLE_DEPTH(DEPTH)) u_dut (
        .clk(clk), .rst_n(rst_n), .req(req_ch.sink), .rsp(rsp_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predicted table and registers
    logic signed [31:0] tbl_x [DEPTH];
    logic signed [31:0] tbl_y [DEPTH];
    int                 tbl_n;
    logic signed [31:0] below_val, above_val;
    logic [15:0]        tol_val;

    request_t  pending_reqs [$];
    response_t expected_rsps [$];
    int        errors;
    int        idle_cycles;
    bit        stim_done;

    function automatic response_t predict_table(request_t r);
        response_t o;
        longint key, d, lo, hi, dy, x1, x2, y1;
        longint unsigned mag, num, den, q;
        bit dup;
        int pos;
        o = '0;
        key = r.key_x;
        if (r.req_type == REQ_CLEAR) begin
            tbl_n = 0;
        end else if (r.req_type == REQ_ADD) begin
            dup = 0;
            for (int i = 0; i < tbl_n; i++) begin
                d = key - longint'(tbl_x[i]);
                if (d < 0) d = -d;
                if (d < longint'(tol_val)) dup = 1;
            end
            if (dup) o.status = ST_DUP;
            else if (tbl_n >= DEPTH) o.status = ST_FULL;
            else begin
                pos = tbl_n;
                while (pos > 0 && longint'(tbl_x[pos-1]) > key) begin
                    tbl_x[pos] = tbl_x[pos-1];
                    tbl_y[pos] = tbl_y[pos-1];
                    pos--;
                end
                tbl_x[pos] = r.key_x;
                tbl_y[pos] = r.value_y;
                tbl_n++;
            end
        end else if (r.req_type == REQ_LOOKUP) begin
            lo = tbl_n ? longint'(tbl_x[0]) : 0;
            hi = tbl_n ? longint'(tbl_x[tbl_n-1]) : 0;
            if (key < lo) begin
                o.result_y = below_val;
                o.status = ST_BELOW;
            end else if (key > hi) begin
                o.result_y = above_val;
                o.status = ST_ABOVE;
            end else if (tbl_n == 0) begin
                o.result_y = 0;
            end else if (key == hi || tbl_n == 1) begin
                o.result_y = tbl_y[tbl_n-1];
            end else begin
                o.result_y = tbl_y[tbl_n-1];
                for (int i = 0; i + 1 < tbl_n; i++) begin
                    if (longint'(tbl_x[i+1]) > key) begin
                        x1 = tbl_x[i];
                        x2 = tbl_x[i+1];
                        y1 = tbl_y[i];
                        dy = longint'(tbl_y[i+1]) - y1;
                        mag = dy < 0 ? -dy : dy;
                        num = key - x1;
                        den = x2 - x1;
                        q = (mag * num) / den;
                        o.result_y = 32'(dy < 0 ? y1 - longint'(q) : y1 + longint'(q));
                        break;
                    end
                end
            end
        end
        o.point_count = 5'(tbl_n);
        return o;
    endfunction

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // request driver
    int src_gap;
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            req_ch.valid <= 0;
            req_ch.req_type <= '0;
            req_ch.key_x <= '0;
            req_ch.value_y <= '0;
            src_gap = 0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                expected_rsps.insert(expected_rsps.size(),
                                     predict_table(pending_reqs.pop_front()));
                src_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                        : ($urandom_range(0, 2) == 0 ? $urandom_range(0, 3) : 0);
            end
            if (src_gap > 0) begin
                src_gap--;
                req_ch.valid <= 0;
            end else if (pending_reqs.size() > 0) begin
                req_ch.valid <= 1;
                req_ch.req_type <= pending_reqs[0].req_type;
                req_ch.key_x <= pending_reqs[0].key_x;
                req_ch.value_y <= pending_reqs[0].value_y;
            end else begin
                req_ch.valid <= 0;
            end
        end
    end

    // response monitor and back-pressure
    int sink_gap;
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rsp_ch.ready <= 0;
            sink_gap = 0;
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (req_ch.valid && req_ch.ready) idle_cycles = 0;
            if (rsp_ch.valid && rsp_ch.ready) begin
                response_t got, exp_r;
                idle_cycles = 0;
                got = '{rsp_ch.result_y, rsp_ch.status, rsp_ch.point_count};
                if (expected_rsps.size() == 0) begin
                    $display("%0t unexpected response actual %h", $time, got);
                    errors++;
                end else begin
                    exp_r = expected_rsps.pop_front();
                    if (got.result_y !== exp_r.result_y)
                        $display("%0t result_y expected %h actual %h", $time,
                                 exp_r.result_y, got.result_y);
                    if (got.status !== exp_r.status)
                        $display("%0t status expected %0d actual %0d", $time,
                                 exp_r.status, got.status);
                    if (got.point_count !== exp_r.point_count)
                        $display("%0t point_count expected %0d actual %0d", $time,
                                 exp_r.point_count, got.point_count);
                    if (got !== exp_r) errors++;
                end
                sink_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                         : ($urandom_range(0, 2) == 0 ? $urandom_range(0, 3) : 0);
            end
            if (sink_gap > 0) begin
                sink_gap--;
                rsp_ch.ready <= 0;
            end else begin
                rsp_ch.ready <= 1;
            end
        end
    end

    // watchdog
    initial begin
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (idle_cycles > WATCHDOG_LIMIT) begin
                $display("tb_sorted_interpolation_table_top NOT OK");
                $finish;
            end
        end
    end

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
        @(posedge clk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= ADDR_W'({idx, 2'b00}); pwdata <= data;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        if (idx == REG_UNDER_VALUE) below_val = data;
        else if (idx == REG_OVER_VALUE) above_val = data;
        else tol_val = data[15:0];
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || expected_rsps.size() > 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic push_req(input logic [1:0] t, input logic [31:0] k,
                            input logic [31:0] v);
        request_t item;
        item = '{t, k, v};
        pending_reqs.insert(pending_reqs.size(), item);
    endtask

    function automatic logic [31:0] rand_key(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 2000)) - 1000);
            default: return 32'($signed($urandom_range(0, 200000)) - 100000) <<< 4;
        endcase
    endfunction

    initial begin
        int mode;
        int sent;
        int r;
        errors = 0;
        tbl_n = 0;
        below_val = 0; above_val = 0; tol_val = TOLERANCE_RESET;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        rst_n = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: empty table, extremes, single point, full and duplicates
        push_req(REQ_LOOKUP, 32'sh8000_0000, 32'hFFFF_FFFF);
        push_req(REQ_LOOKUP, 32'sh7FFF_FFFF, 0);
        push_req(REQ_LOOKUP, 0, 0);
        push_req(REQ_ADD, 32'h0001_0000, 32'h7FFF_FFFF);
        push_req(REQ_LOOKUP, 32'h0001_0000, 0);
        push_req(REQ_ADD, 32'h0001_0010, 5);
        push_req(REQ_ADD, 32'h8000_0000, 32'h8000_0000);
        push_req(REQ_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_req(REQ_LOOKUP, 32'h7FFF_FFFF, 0);
        push_req(REQ_LOOKUP, 32'h0000_8000, 0);
        push_req(REQ_LOOKUP, 32'h4000_0000, 0);
        push_req(REQ_IGNORED, 5, 5);
        for (int i = 0; i < 15; i++) push_req(REQ_ADD, 32'(i * 32'h100_0000 + 7), $urandom());
        push_req(REQ_ADD, 32'h0001_0000, 0);
        push_req(REQ_CLEAR, 0, 0);
        wait_drained();

        // tolerance zero: equal x values, other extreme values
        apb_write(REG_UNDER_VALUE, 32'h8000_0000);
        apb_write(REG_OVER_VALUE, 32'h7FFF_FFFF);
        apb_write(REG_TOLERANCE, 0);
        push_req(REQ_ADD, 100, 1);
        push_req(REQ_ADD, 100, 2);
        push_req(REQ_ADD, 200, 32'h8000_0000);
        push_req(REQ_LOOKUP, 100, 0);
        push_req(REQ_LOOKUP, 150, 0);
        push_req(REQ_LOOKUP, 99, 0);
        push_req(REQ_LOOKUP, 201, 0);
        push_req(REQ_CLEAR, 0, 0);
        wait_drained();

        // random phases, new register settings each phase
        sent = 0;
        for (int ph = 0; ph < 8; ph++) begin
            apb_write(REG_UNDER_VALUE, $urandom());
            apb_write(REG_OVER_VALUE, $urandom());
            case (ph % 4)
                0: apb_write(REG_TOLERANCE, 0);
                1: apb_write(REG_TOLERANCE, 16'hFFFF);
                default: apb_write(REG_TOLERANCE, $urandom_range(0, 200));
            endcase
            mode = ph % 3;
            for (int k = 0; k < 150; k++) begin
                r = $urandom_range(0, 99);
                if (r < 4) push_req(REQ_CLEAR, $urandom(), $urandom());
                else if (r < 5) push_req(REQ_IGNORED, $urandom(), $urandom());
                else if (r < 45) push_req(REQ_ADD, rand_key(mode), $urandom());
                else push_req(REQ_LOOKUP, ($urandom_range(0, 9) == 0) ? $urandom()
                                          : rand_key(mode), $urandom());
                sent++;
            end
            wait_drained();
        end

        if (errors == 0)
            $display("tb_sorted_interpolation_table_top OK");
        else
            $display("tb_sorted_interpolation_table_top NOT OK");
        $finish;
    end
endmodule
